FILE: src/mme_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies; compiled first.
`default_nettype none

package mme_pkg;

    // Width of the data fields on the request channels
    localparam int unsigned IF_BITS = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new request, acc <= 1
        logic mul_start;  // clear both multipliers and latch their b operands
        logic mul_step;   // one bit step of both multipliers
        logic red_sel;    // unit B reduces the base (a = 1, b = base)
        logic take_red;   // sq <= reduced base
        logic take_bit;   // update sq and, on a set exponent bit, acc; shift the exponent
        logic write_out;  // load the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/mme_if.sv
// Request channel interfaces: operands in, result out.
// Depends on mme_pkg for the field width.
`default_nettype none

interface mme_in_if;
    import mme_pkg::*;
    logic               valid;
    logic               ready;
    logic [IF_BITS-1:0] base;
    logic [IF_BITS-1:0] exponent;
    logic [IF_BITS-1:0] modulus;

    modport source (output valid, base, exponent, modulus, input ready);
    modport sink   (input valid, base, exponent, modulus, output ready);
endinterface

interface mme_out_if;
    import mme_pkg::*;
    logic               valid;
    logic               ready;
    logic [IF_BITS-1:0] power_mod;
    logic               bad_modulus;

    modport source (output valid, power_mod, bad_modulus, input ready);
    modport sink   (input valid, power_mod, bad_modulus, output ready);
endinterface

`default_nettype wire

FILE: src/mme_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m in WORD_BITS steps, top bit of b first.
// Requires p < m and a <= m; no package dependency.
`default_nettype none

module mme_mulmod #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire logic                 step,
    input  wire logic [WORD_BITS-1:0] a,
    input  wire logic [WORD_BITS-1:0] b,
    input  wire logic [WORD_BITS-1:0] m,
    output logic      [WORD_BITS-1:0] prod
);

    localparam int unsigned TW = WORD_BITS + 2;

    logic [WORD_BITS-1:0] prod_reg, prod_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [TW-1:0]        t, d1, d2;

    // t = 2p + bit*a < 3m; pick t, t-m or t-2m, whichever lands in [0, m)
    always_comb
    begin
        t  = {1'b0, prod_reg, 1'b0} + (b_reg[WORD_BITS-1] ? {2'b00, a} : '0);
        d1 = t - {2'b00, m};
        d2 = t - {1'b0, m, 1'b0};
        prod_next = prod_reg;
        b_next    = b_reg;
        if (load)
        begin
            prod_next = '0;
            b_next    = b;
        end
        else if (step)
        begin
            b_next = {b_reg[WORD_BITS-2:0], 1'b0};
            priority if (!d2[TW-1])
                prod_next = d2[WORD_BITS-1:0];
            else if (!d1[TW-1])
                prod_next = d1[WORD_BITS-1:0];
            else
                prod_next = t[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        b_reg    <= b_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: src/mme_datapath.sv
// Datapath: operand registers, accumulator, square register, two modular multipliers
// and the output payload register. Depends on mme_pkg and mme_mulmod.
`default_nettype none

module mme_datapath #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [mme_pkg::IF_BITS-1:0]  in_base,
    input  wire logic [mme_pkg::IF_BITS-1:0]  in_exponent,
    input  wire logic [mme_pkg::IF_BITS-1:0]  in_modulus,
    input  wire mme_pkg::ctrl_cmd_t           cmd,
    output mme_pkg::dp_status_t               status,
    output logic      [mme_pkg::IF_BITS-1:0]  power_mod,
    output logic                              bad_modulus
);
    import mme_pkg::*;

    localparam int unsigned IW = (WORD_BITS > IF_BITS) ? WORD_BITS : IF_BITS;

    logic [WORD_BITS-1:0] base_reg, exp_reg, mod_reg, acc_reg, sq_reg;
    logic [WORD_BITS-1:0] base_next, exp_next, mod_next, acc_next, sq_next;
    logic [IF_BITS-1:0]   res_reg, res_next;
    logic                 bad_reg, bad_next;
    logic [IW-1:0]        base_x, exp_x, mod_x, acc_x;
    logic [WORD_BITS-1:0] b_a_op, b_b_op;
    logic [WORD_BITS-1:0] prod_a, prod_b;

    // Inputs are taken in their low WORD_BITS bits
    assign base_x = IW'(in_base);
    assign exp_x  = IW'(in_exponent);
    assign mod_x  = IW'(in_modulus);
    assign acc_x  = IW'(acc_reg);

    // Unit A: acc * sq.  Unit B: sq * sq, or base mod m while reducing.
    assign b_a_op = cmd.red_sel ? WORD_BITS'(1) : sq_reg;
    assign b_b_op = cmd.red_sel ? base_reg : sq_reg;

    mme_mulmod #(.WORD_BITS(WORD_BITS)) u_mul_acc (
        .clk  (clk),
        .load (cmd.mul_start),
        .step (cmd.mul_step),
        .a    (acc_reg),
        .b    (sq_reg),
        .m    (mod_reg),
        .prod (prod_a)
    );

    mme_mulmod #(.WORD_BITS(WORD_BITS)) u_mul_sq (
        .clk  (clk),
        .load (cmd.mul_start),
        .step (cmd.mul_step),
        .a    (b_a_op),
        .b    (b_b_op),
        .m    (mod_reg),
        .prod (prod_b)
    );

    // Register updates
    always_comb
    begin
        base_next = base_reg;
        exp_next  = exp_reg;
        mod_next  = mod_reg;
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        res_next  = res_reg;
        bad_next  = bad_reg;
        if (cmd.load)
        begin
            base_next = base_x[WORD_BITS-1:0];
            exp_next  = exp_x[WORD_BITS-1:0];
            mod_next  = mod_x[WORD_BITS-1:0];
            acc_next  = WORD_BITS'(1);
        end
        if (cmd.take_red)
            sq_next = prod_b;
        if (cmd.take_bit)
        begin
            sq_next  = prod_b;
            exp_next = {1'b0, exp_reg[WORD_BITS-1:1]};
            if (exp_reg[0])
                acc_next = prod_a;
        end
        if (cmd.write_out)
        begin
            bad_next = (mod_reg == '0);
            res_next = (mod_reg == '0) ? '0 : acc_x[IF_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
        bad_reg  <= bad_next;
    end

    assign status.mod_zero = (mod_reg == '0);
    assign status.exp_zero = (exp_reg == '0);
    assign power_mod       = res_reg;
    assign bad_modulus     = bad_reg;

    // Reduced square stays below the modulus
    a_sq_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_red || cmd.take_bit) |=> (sq_reg < mod_reg))
        else $error("square register not reduced");

    // Accumulator is below the modulus after a multiply was taken
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_bit && exp_reg[0]) |=> (acc_reg < mod_reg))
        else $error("accumulator not reduced");

    // Partial products stay reduced during the exponent multiply passes
    a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_step && !cmd.red_sel) |=> (prod_a < mod_reg && prod_b < mod_reg))
        else $error("partial product out of range");

endmodule

`default_nettype wire

FILE: src/mme_ctrl.sv
// Controller: sequences load, base reduction, one multiply pass per significant
// exponent bit and the output register handshake. Depends on mme_pkg.
`default_nettype none

module mme_ctrl #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire mme_pkg::dp_status_t status,
    output mme_pkg::ctrl_cmd_t       cmd
);
    import mme_pkg::*;

    localparam int unsigned CW = $clog2(WORD_BITS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_RED   = 7'b0000100,
        S_SQ    = 7'b0001000,
        S_CHK   = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           out_valid_reg, out_valid_next;
    logic           upd_reg, upd_next;
    logic           cnt_last;
    logic           out_free;

    assign cnt_last = (cnt_reg == CW'(WORD_BITS - 1));
    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        upd_next   = 1'b0;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (status.mod_zero)
                    state_next = S_DONE;
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.red_sel   = 1'b1;
                    state_next    = S_RED;
                end
            end
            S_RED:
            begin
                cmd.mul_step = 1'b1;
                cmd.red_sel  = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.take_red = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                // upd_reg: a multiply pass just finished, take its results first
                if (upd_reg)
                    cmd.take_bit = 1'b1;
                else if (status.exp_zero)
                    state_next = S_DONE;
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    upd_next   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.write_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            upd_reg       <= upd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // A multiply pass always starts from a zero step count
    a_cnt_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |=> (cnt_reg == '0 && cmd.mul_step))
        else $error("multiply pass started with stale count");

    // Exponent bits are consumed only right after a full pass
    a_take_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_bit |-> ($past(state_reg) == S_MUL && $past(cnt_last)))
        else $error("exponent bit taken without a finished pass");

endmodule

`default_nettype wire

FILE: src/modular_exponentiation_top.sv
// Modular exponentiation, right-to-left square-and-multiply with bit-serial reduction.
// Order: base reduction, then one multiply pass per significant exponent bit, then the
// output write (W = WORD_BITS); a zero modulus goes straight to the output write.
// Throughput: one request at a time; each significant exponent bit costs one W-step pass
// of the two serial multipliers, which run the acc and square products side by side.
// Reset: rst_n asynchronous, clears controller and output valid; no clearing pass.
`default_nettype none

module modular_exponentiation_top #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mme_in_if.sink     operands,
    mme_out_if.source  result
);
    import mme_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mme_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mme_datapath #(.WORD_BITS(WORD_BITS)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_base     (operands.base),
        .in_exponent (operands.exponent),
        .in_modulus  (operands.modulus),
        .cmd         (cmd),
        .status      (status),
        .power_mod   (result.power_mod),
        .bad_modulus (result.bad_modulus)
    );

endmodule

`default_nettype wire

FILE: sim/modular_exponentiation_top_tb.sv
// Self-checking bench for modular_exponentiation_top: directed and random requests, with
// random idling. Depends on mme_pkg, mme_in_if/mme_out_if and the block itself.
`default_nettype none

module modular_exponentiation_top_tb;
    import mme_pkg::*;

    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned RAND_COUNT  = 250;
    localparam int unsigned CALM_TAIL   = 25;     // last requests/results with no idling
    localparam int unsigned HOLD_CYCLES = 600;    // long receiver hold-off
    localparam int unsigned HOLD_AT     = 40;     // results seen before the hold-off
    localparam int unsigned STALL_LIMIT = 10000;  // watchdog, cycles with no handshake
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct {
        logic [IF_BITS-1:0] base;
        logic [IF_BITS-1:0] exponent;
        logic [IF_BITS-1:0] modulus;
    } power_request_t;

    typedef struct {
        power_request_t     req;
        logic [IF_BITS-1:0] power_mod;
        logic               bad_modulus;
    } power_result_t;

    logic clk;
    logic rst_n;

    mme_in_if  operands ();
    mme_out_if result ();

    modular_exponentiation_top #(
        .WORD_BITS (WORD_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .result   (result)
    );

    power_request_t pending_requests[$];
    power_result_t  expected_powers[$];

    int unsigned total_requests;
    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned send_idle_left;
    int unsigned recv_stall_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned quiet_cycles;

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Expected power: square-and-multiply, every product reduced at 64 bits
    function automatic power_result_t predict_power(power_request_t req);
        power_result_t r;
        logic [63:0]   mask;
        logic [63:0]   b;
        logic [63:0]   e;
        logic [63:0]   m;
        logic [63:0]   acc;
        logic [63:0]   sq;
        mask = (WORD_BITS >= 64) ? '1 : ((64'd1 << WORD_BITS) - 64'd1);
        b = 64'(req.base) & mask;
        e = 64'(req.exponent) & mask;
        m = 64'(req.modulus) & mask;
        r.req = req;
        if (m == 64'd0)
        begin
            r.power_mod   = '0;
            r.bad_modulus = 1'b1;
            return r;
        end
        acc = 64'd1;
        sq  = b % m;
        while (e != 64'd0)
        begin
            // acc stays 1 until the first set bit, even for a modulus of one
            if (e[0])
                acc = ((acc % m) * sq) % m;
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        r.power_mod   = acc[IF_BITS-1:0];
        r.bad_modulus = 1'b0;
        return r;
    endfunction

    function automatic power_request_t make_request(logic [IF_BITS-1:0] b,
                                                    logic [IF_BITS-1:0] e,
                                                    logic [IF_BITS-1:0] m);
        power_request_t req;
        req.base     = b;
        req.exponent = e;
        req.modulus  = m;
        return req;
    endfunction

    // Random request: full and short exponents, mixed modulus sizes
    function automatic power_request_t random_request();
        logic [IF_BITS-1:0] b;
        logic [IF_BITS-1:0] e;
        logic [IF_BITS-1:0] m;
        case ($urandom_range(0, 7))
            0:       b = $urandom_range(0, 1) ? '0 : '1;
            1:       b = $urandom_range(0, 255);
            default: b = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       e = $urandom_range(0, 3);
            1, 2, 3: e = $urandom >> $urandom_range(1, 31);
            default: e = $urandom;
        endcase
        case ($urandom_range(0, 19))
            0:          m = '0;
            1:          m = 32'd1;
            2, 3, 4:    m = $urandom_range(2, 1000);
            5, 6, 7, 8: m = $urandom | 32'h8000_0000;
            default:    m = $urandom;
        endcase
        return make_request(b, e, m);
    endfunction

    // Stimulus, reset and end of run
    initial
    begin
        rst_n = 1'b0;

        // zero modulus
        pending_requests.push_back(make_request(32'd5, 32'd3, 32'd0));
        pending_requests.push_back(make_request('1, '1, 32'd0));
        pending_requests.push_back(make_request(32'd0, 32'd0, 32'd0));
        // zero exponent gives 1 for any nonzero modulus, one included
        pending_requests.push_back(make_request(32'd7, 32'd0, 32'd1));
        pending_requests.push_back(make_request('1, 32'd0, '1));
        pending_requests.push_back(make_request(32'd0, 32'd0, 32'd13));
        // modulus of one with a nonzero exponent
        pending_requests.push_back(make_request(32'd9, 32'd1, 32'd1));
        pending_requests.push_back(make_request('1, '1, 32'd1));
        // field extremes
        pending_requests.push_back(make_request('1, '1, '1));
        pending_requests.push_back(make_request('1, '1, 32'hFFFF_FFFB));
        pending_requests.push_back(make_request(32'd0, '1, '1));
        pending_requests.push_back(make_request(32'd0, 32'd5, 32'd7));
        pending_requests.push_back(make_request('1, 32'd1, 32'h8000_0000));
        pending_requests.push_back(make_request(32'hDEAD_BEEF, '1, 32'h8000_0000));
        // base reduced before use, base equal to modulus
        pending_requests.push_back(make_request(32'd100, 32'd1, 32'd7));
        pending_requests.push_back(make_request(32'd12345, 32'd9, 32'd12345));
        pending_requests.push_back(make_request(32'd3, 32'd1, 32'd2));
        // Fermat: 3^(p-1) mod p == 1 for the prime 2^32-5
        pending_requests.push_back(make_request(32'd3, 32'hFFFF_FFFA, 32'hFFFF_FFFB));
        pending_requests.push_back(make_request(32'd2, 32'd31, '1));
        pending_requests.push_back(make_request(32'h8000_0001, 32'h8000_0000, 32'hFFFF_FFFE));
        repeat (RAND_COUNT)
            pending_requests.push_back(random_request());
        total_requests = pending_requests.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (requests_sent < total_requests || expected_powers.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_powers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        bit took;
        if (!rst_n)
        begin
            operands.valid    <= 1'b0;
            operands.base     <= '0;
            operands.exponent <= '0;
            operands.modulus  <= '0;
            send_idle_left    = 0;
            requests_sent     = 0;
        end
        else
        begin
            took = operands.valid && operands.ready;
            if (took)
            begin
                expected_powers.push_back(predict_power(make_request(
                    operands.base, operands.exponent, operands.modulus)));
                void'(pending_requests.pop_front());
                requests_sent++;
            end
            if (!operands.valid || took)
            begin
                if (send_idle_left == 0 && pending_requests.size() > CALM_TAIL &&
                    $urandom_range(0, 5) == 0)
                    send_idle_left = $urandom_range(1, 19);
                if (send_idle_left > 0)
                begin
                    send_idle_left--;
                    operands.valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    operands.valid    <= 1'b1;
                    operands.base     <= pending_requests[0].base;
                    operands.exponent <= pending_requests[0].exponent;
                    operands.modulus  <= pending_requests[0].modulus;
                end
                else
                    operands.valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        power_result_t want;
        if (!rst_n)
        begin
            result.ready    <= 1'b0;
            recv_stall_left = 0;
            hold_left       = 0;
            hold_done       = 1'b0;
            results_seen    = 0;
            mismatches      = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                results_seen++;
                if (expected_powers.size() == 0)
                begin
                    $display("%0t: result with no request pending: expected none, got %h/%b",
                             $time, result.power_mod, result.bad_modulus);
                    mismatches++;
                end
                else
                begin
                    want = expected_powers.pop_front();
                    if (result.power_mod !== want.power_mod)
                    begin
                        $display("%0t: power_mod for %h^%h mod %h: expected %h, got %h",
                                 $time, want.req.base, want.req.exponent, want.req.modulus,
                                 want.power_mod, result.power_mod);
                        mismatches++;
                    end
                    if (result.bad_modulus !== want.bad_modulus)
                    begin
                        $display("%0t: bad_modulus for %h^%h mod %h: expected %b, got %b",
                                 $time, want.req.base, want.req.exponent, want.req.modulus,
                                 want.bad_modulus, result.bad_modulus);
                        mismatches++;
                    end
                end
            end

            // one long hold-off so the block backs up and stalls its input
            if (!hold_done && results_seen == HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (recv_stall_left == 0 && results_seen + CALM_TAIL < total_requests &&
                $urandom_range(0, 7) == 0)
                recv_stall_left = $urandom_range(1, 19);

            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (operands.valid && operands.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

`default_nettype wire

FILE: files.f
src/mme_pkg.sv
src/mme_if.sv
src/mme_mulmod.sv
src/mme_datapath.sv
src/mme_ctrl.sv
src/modular_exponentiation_top.sv
sim/modular_exponentiation_top_tb.sv
